// ----- sv/swta_pkg.sv -----
// shared types and constants for the sleep/wake time arbiter
// no dependencies; imported by every module of the block
package swta_pkg;

	localparam int LANES = 8;
	localparam int TW = 64;

	typedef logic [TW-1:0] time_t;

	localparam time_t ALL_ONES  = '1;
	localparam time_t VOTE_LOCK = {{(TW-1){1'b1}}, 1'b0};

	typedef enum logic [2:0] {
		OUT_SLEEP     = 3'd0,
		OUT_DISABLED  = 3'd1,
		OUT_SETTLING  = 3'd2,
		OUT_LOCKED    = 3'd3,
		OUT_TOO_SHORT = 3'd4
	} outcome_t;

	typedef enum logic [1:0] {
		REG_MIN_SLEEP = 2'd0,
		REG_MAX_SLEEP = 2'd1,
		REG_ENABLE    = 2'd2,
		REG_CLIENTS   = 2'd3
	} reg_idx_t;

	// load enables for the stages of the min tree
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} tree_adv_t;

endpackage

// ----- sv/swta_lane.sv -----
// one client vote lane: flags a lock and passes a usable wake time
// depends on swta_pkg
module swta_lane (
	input  logic           active,
	input  swta_pkg::time_t time_now,
	input  swta_pkg::time_t vote,
	output swta_pkg::time_t cand,
	output logic           lock
);
	import swta_pkg::*;

	always_comb begin
		lock = active && (vote == VOTE_LOCK);
		// unlock votes, lock votes and past times never win the min
		if (active && (vote != ALL_ONES) && (vote != VOTE_LOCK) && (vote >= time_now)) begin
			cand = vote;
		end else begin
			cand = ALL_ONES;
		end
	end

endmodule

// ----- sv/swta_merge.sv -----
// registered min tree that merges the lane candidates, one level per stage
// depends on swta_pkg
module swta_merge (
	input  logic            clk,
	input  swta_pkg::tree_adv_t adv,
	input  swta_pkg::time_t cand_s1 [swta_pkg::LANES],
	output swta_pkg::time_t min_s4
);
	import swta_pkg::*;

	time_t lvl1_s2 [LANES/2];
	time_t lvl2_s3 [LANES/4];

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			for (int i = 0; i < LANES/2; i++) begin
				lvl1_s2[i] <= (cand_s1[2*i] < cand_s1[2*i+1]) ? cand_s1[2*i] : cand_s1[2*i+1];
			end
		end
		if (adv.s3) begin
			for (int i = 0; i < LANES/4; i++) begin
				lvl2_s3[i] <= (lvl1_s2[2*i] < lvl1_s2[2*i+1]) ? lvl1_s2[2*i] : lvl1_s2[2*i+1];
			end
		end
		if (adv.s4) begin
			min_s4 <= (lvl2_s3[0] < lvl2_s3[1]) ? lvl2_s3[0] : lvl2_s3[1];
		end
	end

endmodule

// ----- sv/sleep_wake_time_arbiter.sv -----
// channel  | dir | handshake              | payload
// s_axis   | in  | s_tvalid / s_tready    | s_tdata: time_now, client_wake_0..7
// m_axis   | out | m_tvalid / m_tready    | m_tdata: sleep_request, wake_time, outcome
// apb cfg  | in  | psel, penable, pwrite  | paddr, pwdata, prdata; pready tied high
//
// one pass is accepted per cycle while the stages ahead are not stalled; a result goes
// through lane compare, three min-tree levels, window check and decision register
// each stage holds its item only while the next one is full, so a waiting
// result stalls just the stages behind it
// arst_n clears stage valid bits, config registers and the pass counter
// depends on swta_pkg, swta_lane, swta_merge
module sleep_wake_time_arbiter #(
	parameter int NUM_CLIENTS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	// slave stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [575:0] s_tdata,   // time_now[63:0], client_wake_0..7 64 bits each
	// master stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,   // sleep_request[0], wake_time[64:1], outcome[67:65], zeros
	// config port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import swta_pkg::*;

	localparam logic [3:0] NC = 4'(NUM_CLIENTS);

	// config registers
	logic [30:0] min_sleep_q;
	logic [30:0] max_sleep_q;
	logic        enable_q;
	logic [3:0]  clients_q;
	reg_idx_t    reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sleep_q <= '0;
			max_sleep_q <= '0;
			enable_q    <= 1'b0;
			clients_q   <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_MIN_SLEEP: min_sleep_q <= pwdata[30:0];
				REG_MAX_SLEEP: max_sleep_q <= pwdata[30:0];
				REG_ENABLE:    enable_q    <= pwdata[0];
				REG_CLIENTS:   clients_q   <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_MIN_SLEEP: prdata = {1'b0, min_sleep_q};
			REG_MAX_SLEEP: prdata = {1'b0, max_sleep_q};
			REG_ENABLE:    prdata = {31'd0, enable_q};
			REG_CLIENTS:   prdata = {28'd0, clients_q};
			default:       prdata = '0;
		endcase
	end

	// stage flow control
	logic v1_q, v2_q, v3_q, v4_q, v5_q, mv_q;
	logic adv1, adv2, adv3, adv4, adv5, adv_out;
	tree_adv_t tree_adv;

	assign adv_out  = !mv_q || m_tready;
	assign adv5     = !v5_q || adv_out;
	assign adv4     = !v4_q || adv5;
	assign adv3     = !v3_q || adv4;
	assign adv2     = !v2_q || adv3;
	assign adv1     = !v1_q || adv2;
	assign s_tready = adv1;
	assign tree_adv = '{s2: adv2, s3: adv3, s4: adv4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
			mv_q <= 1'b0;
		end else begin
			if (adv1)    v1_q <= s_tvalid;
			if (adv2)    v2_q <= v1_q;
			if (adv3)    v3_q <= v2_q;
			if (adv4)    v4_q <= v3_q;
			if (adv5)    v5_q <= v4_q;
			if (adv_out) mv_q <= v5_q;
		end
	end

	// lanes
	time_t      now_in;
	logic [3:0] lanes_used;
	time_t      cand [LANES];
	logic [LANES-1:0] lock;

	assign now_in     = s_tdata[TW-1:0];
	assign lanes_used = (clients_q > NC) ? NC : clients_q;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		swta_lane u_lane (
			.active   ((i < NUM_CLIENTS) && (4'(i) < lanes_used)),
			.time_now (now_in),
			.vote     (s_tdata[TW*(i+1) +: TW]),
			.cand     (cand[i]),
			.lock     (lock[i])
		);
	end

	// window bounds, saturating
	logic [TW:0] lo_sum, hi_sum;
	assign lo_sum = {1'b0, now_in} + (TW+1)'(min_sleep_q);
	assign hi_sum = {1'b0, now_in} + (TW+1)'(max_sleep_q);

	time_t cand_s1 [LANES];
	time_t lo_s1, hi_s1, lo_s2, hi_s2, lo_s3, hi_s3, lo_s4, hi_s4;
	logic  lock_s1, lock_s2, lock_s3, lock_s4, lock_s5;
	time_t min_s4;
	time_t capped_s5;
	logic  short_s5;

	always_ff @(posedge clk) begin
		if (adv1) begin
			cand_s1 <= cand;
			lock_s1 <= |lock;
			lo_s1   <= lo_sum[TW] ? ALL_ONES : lo_sum[TW-1:0];
			hi_s1   <= hi_sum[TW] ? ALL_ONES : hi_sum[TW-1:0];
		end
		if (adv2) begin
			lock_s2 <= lock_s1;
			lo_s2   <= lo_s1;
			hi_s2   <= hi_s1;
		end
		if (adv3) begin
			lock_s3 <= lock_s2;
			lo_s3   <= lo_s2;
			hi_s3   <= hi_s2;
		end
		if (adv4) begin
			lock_s4 <= lock_s3;
			lo_s4   <= lo_s3;
			hi_s4   <= hi_s3;
		end
		if (adv5) begin
			lock_s5   <= lock_s4;
			short_s5  <= min_s4 < lo_s4;
			capped_s5 <= (min_s4 > hi_s4) ? hi_s4 : min_s4;
		end
	end

	swta_merge u_merge (
		.clk     (clk),
		.adv     (tree_adv),
		.cand_s1 (cand_s1),
		.min_s4  (min_s4)
	);

	// decision, kept in pass order so the settle count sees every earlier sleep
	logic [1:0] passes_q, passes_nxt;
	logic       req_nxt;
	time_t      wake_nxt;
	outcome_t   outcome_nxt;

	always_comb begin
		passes_nxt  = passes_q;
		req_nxt     = 1'b0;
		wake_nxt    = '0;
		outcome_nxt = OUT_DISABLED;
		if (enable_q) begin
			if (passes_q == 2'd0) begin
				passes_nxt  = 2'd1;
				outcome_nxt = OUT_SETTLING;
			end else begin
				passes_nxt = 2'd2;
				if (lock_s5) begin
					outcome_nxt = OUT_LOCKED;
				end else if (short_s5) begin
					outcome_nxt = OUT_TOO_SHORT;
				end else begin
					passes_nxt  = 2'd0;
					req_nxt     = 1'b1;
					outcome_nxt = OUT_SLEEP;
					wake_nxt    = (capped_s5 == ALL_ONES) ? ALL_ONES : capped_s5 + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			passes_q <= 2'd0;
		end else if (adv_out && v5_q) begin
			passes_q <= passes_nxt;
		end
	end

	logic     req_q;
	time_t    wake_q;
	outcome_t outcome_q;

	always_ff @(posedge clk) begin
		if (adv_out && v5_q) begin
			req_q     <= req_nxt;
			wake_q    <= wake_nxt;
			outcome_q <= outcome_nxt;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = {4'd0, outcome_q, wake_q, req_q};

endmodule
